>>> design/cpf_pkg.sv
// Shared types, constants and kernel helpers for the 3x3 preset filter.
// No dependencies; every other design file but cpf_ram uses this package.

package cpf_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int MIN_SIZE   = 3;

    localparam int PIX_W    = 8;
    localparam int ADDR_W   = $clog2(MAX_WIDTH);
    localparam int COL_W    = 10;
    localparam int ROW_W    = 12;
    localparam int KIND_W   = 3;
    localparam int WIDTH_W  = 11;
    localparam int HEIGHT_W = 13;

    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = 2;

    localparam int Q_DEPTH = 4;
    localparam int QPTR_W  = $clog2(Q_DEPTH);
    localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

    localparam int SUM_W    = 13;
    localparam int MAG_W    = 12;
    localparam int RECIP_W  = 16;
    localparam int RECIP_SH = 18;
    localparam logic [RECIP_W-1:0] RECIP_5 = RECIP_W'(52429);
    localparam int OFFSET   = 128;

    typedef logic [PIX_W-1:0] pix_t;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_KIND   = 2'd0,
        REG_WIDTH  = 2'd1,
        REG_HEIGHT = 2'd2
    } reg_idx_e;

    typedef enum logic [KIND_W-1:0] {
        FK_SMOOTH      = 3'd0,
        FK_EMBOSS      = 3'd1,
        FK_SHARPEN     = 3'd2,
        FK_LAPLACE     = 3'd3,
        FK_RELIEF_DIAG = 3'd4,
        FK_RELIEF_VERT = 3'd5
    } kind_e;

    typedef enum logic [2:0] {
        DIV_1,
        DIV_2,
        DIV_4,
        DIV_5,
        DIV_8
    } div_e;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [WIDTH_W-1:0]  width;
        logic [HEIGHT_W-1:0] height;
    } cfg_t;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
    } meta_t;

    // win[row*3 + col], row 0 is the top row, col 0 the oldest column
    typedef struct packed {
        pix_t [8:0] win;
        meta_t      meta;
    } job_t;

    function automatic div_e kernel_div(input logic [KIND_W-1:0] kind);
        div_e d;
        case (kind_e'(kind))
            FK_SMOOTH:      d = DIV_8;
            FK_EMBOSS:      d = DIV_4;
            FK_SHARPEN:     d = DIV_5;
            FK_LAPLACE:     d = DIV_1;
            FK_RELIEF_DIAG: d = DIV_1;
            FK_RELIEF_VERT: d = DIV_2;
            default:        d = DIV_1;
        endcase
        return d;
    endfunction

    function automatic logic kernel_offset(input logic [KIND_W-1:0] kind);
        logic o;
        case (kind_e'(kind))
            FK_SHARPEN,
            FK_LAPLACE,
            FK_RELIEF_DIAG,
            FK_RELIEF_VERT: o = 1'b1;
            default:        o = 1'b0;
        endcase
        return o;
    endfunction

endpackage

>>> design/cpf_pixel_if.sv
// Pixel input channel: valid/ready handshake carrying one raster pixel.
// Depends on cpf_pkg for the pixel type.

interface cpf_pixel_if;
    logic          valid;
    logic          ready;
    cpf_pkg::pix_t pixel;
    logic          frame_start;

    modport source (output valid, output pixel, output frame_start, input ready);
    modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

>>> design/cpf_result_if.sv
// Result output channel: valid/ready handshake carrying one filtered pixel.
// Depends on cpf_pkg for widths.

interface cpf_result_if;
    logic                        valid;
    logic                        ready;
    cpf_pkg::pix_t               filtered;
    logic [cpf_pkg::ROW_W-1:0]   centre_row;
    logic [cpf_pkg::COL_W-1:0]   centre_col;
    logic                        last;

    modport source (output valid, output filtered, output centre_row,
                    output centre_col, output last, input ready);
    modport sink   (input valid, input filtered, input centre_row,
                    input centre_col, input last, output ready);
endinterface

>>> design/cpf_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.

module cpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

>>> design/cpf_regs.sv
// APB configuration registers: kernel select, line width, frame height.
// Depends on cpf_pkg; hands clamped sizes to the rest of the block.

module cpf_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [cpf_pkg::PADDR_W-1:0]  paddr,
    input  logic [cpf_pkg::PDATA_W-1:0]  pwdata,
    output logic [cpf_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    output cpf_pkg::cfg_t                cfg
);
    import cpf_pkg::*;

    logic [KIND_W-1:0]   kind_reg;
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic                wr_en;
    reg_idx_e            idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_e'(paddr[REG_IDX_W+1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg   <= KIND_W'(0);
            width_reg  <= WIDTH_W'(640);
            height_reg <= HEIGHT_W'(480);
        end
        else if (wr_en)
        begin
            case (idx)
                REG_KIND:   kind_reg   <= pwdata[KIND_W-1:0];
                REG_WIDTH:  width_reg  <= pwdata[WIDTH_W-1:0];
                REG_HEIGHT: height_reg <= pwdata[HEIGHT_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_KIND:   prdata = PDATA_W'(kind_reg);
            REG_WIDTH:  prdata = PDATA_W'(width_reg);
            REG_HEIGHT: prdata = PDATA_W'(height_reg);
            default:    prdata = '0;
        endcase
    end

    // clamp sizes into the supported range
    always_comb
    begin
        cfg.kind = kind_reg;
        if (width_reg < WIDTH_W'(MIN_SIZE))
        begin
            cfg.width = WIDTH_W'(MIN_SIZE);
        end
        else if (width_reg > WIDTH_W'(MAX_WIDTH))
        begin
            cfg.width = WIDTH_W'(MAX_WIDTH);
        end
        else
        begin
            cfg.width = width_reg;
        end
        if (height_reg < HEIGHT_W'(MIN_SIZE))
        begin
            cfg.height = HEIGHT_W'(MIN_SIZE);
        end
        else if (height_reg > HEIGHT_W'(MAX_HEIGHT))
        begin
            cfg.height = HEIGHT_W'(MAX_HEIGHT);
        end
        else
        begin
            cfg.height = height_reg;
        end
    end
endmodule

>>> design/cpf_queue.sv
// Short job queue between the window front end and the arithmetic back end.
// Depends on cpf_pkg for the job type and depth.

module cpf_queue (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  cpf_pkg::job_t                push_job,
    input  logic                         pop,
    output logic                         q_valid,
    output cpf_pkg::job_t                q_job,
    output logic [cpf_pkg::QCNT_W-1:0]   count
);
    import cpf_pkg::*;

    job_t              ent_reg [Q_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_pop;

    assign q_valid = (count_reg != '0);
    assign q_job   = ent_reg[rd_ptr_reg];
    assign count   = count_reg;
    assign do_pop  = pop && q_valid;

    always_comb
    begin
        count_next = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push && !do_pop |-> count_reg != QCNT_W'(Q_DEPTH))
        else $error("job queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_valid)
        else $error("job queue popped while empty");

    a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        push && !do_pop |=> count_reg == $past(count_reg) + QCNT_W'(1))
        else $error("job queue count out of step with pushes");
endmodule

>>> design/cpf_front.sv
// Front end: raster position counters, line store access and the 3x3 window.
// Depends on cpf_pkg, cpf_pixel_if and cpf_ram; feeds jobs to cpf_queue.

module cpf_front (
    input  logic                        clk,
    input  logic                        rst_n,
    cpf_pixel_if.sink                   pix,
    input  cpf_pkg::cfg_t               cfg,
    input  logic [cpf_pkg::QCNT_W-1:0]  q_count,
    output logic                        push,
    output cpf_pkg::job_t               push_job
);
    import cpf_pkg::*;

    logic              clear_busy_reg;
    logic [ADDR_W-1:0] clear_addr_reg;

    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;

    logic              s1_valid_reg;
    pix_t              s1_px_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic              s1_emit_reg;
    logic [ROW_W-1:0]  s1_row_reg;
    logic [COL_W-1:0]  s1_col_reg;
    logic              s1_last_reg;

    logic fwd_hit_reg;
    pix_t fwd_a_reg;
    pix_t fwd_b_reg;

    pix_t [8:0] win_reg;
    pix_t [8:0] win_next;

    logic              acc;
    logic [QCNT_W:0]   fill;
    logic [ROW_W-1:0]  cur_r;
    logic [COL_W-1:0]  cur_c;
    logic              emit;
    logic              last_px;
    pix_t              up1;
    pix_t              up2;

    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_waddr;
    logic [2*PIX_W-1:0]     ram_wdata;
    logic [2*PIX_W-1:0]     ram_rdata;

    // one entry holds {row above, two rows above} for a column
    cpf_ram #(
        .WIDTH (2*PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (acc),
        .raddr (cur_c[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    // leave room for the item already in the store stage
    assign fill      = {1'b0, q_count} + {{QCNT_W{1'b0}}, s1_valid_reg};
    assign pix.ready = !clear_busy_reg && (fill < (QCNT_W+1)'(Q_DEPTH));
    assign acc       = pix.valid && pix.ready;

    assign cur_r = pix.frame_start ? '0 : row_reg;
    assign cur_c = pix.frame_start ? '0 : col_reg;

    assign emit = (cur_r >= ROW_W'(2)) && (cur_c >= COL_W'(2))
               && ({1'b0, cur_r} < cfg.height) && ({1'b0, cur_c} < cfg.width);
    assign last_px = ({1'b0, cur_r} == cfg.height - HEIGHT_W'(1))
                  && ({1'b0, cur_c} == cfg.width - WIDTH_W'(1));

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (acc)
        begin
            if (({1'b0, cur_c} + WIDTH_W'(1)) >= cfg.width)
            begin
                col_next = '0;
                if (({1'b0, cur_r} + HEIGHT_W'(1)) >= cfg.height)
                begin
                    row_next = '0;
                end
                else
                begin
                    row_next = cur_r + ROW_W'(1);
                end
            end
            else
            begin
                col_next = cur_c + COL_W'(1);
                row_next = cur_r;
            end
        end
    end

    // back-to-back items on the same column see the write still in flight
    assign up1 = fwd_hit_reg ? fwd_a_reg : ram_rdata[2*PIX_W-1:PIX_W];
    assign up2 = fwd_hit_reg ? fwd_b_reg : ram_rdata[PIX_W-1:0];

    always_comb
    begin
        win_next = win_reg;
        if (s1_valid_reg)
        begin
            for (int i = 0; i < 3; i++)
            begin
                win_next[i*3]     = win_reg[i*3 + 1];
                win_next[i*3 + 1] = win_reg[i*3 + 2];
            end
            win_next[2] = up2;
            win_next[5] = up1;
            win_next[8] = s1_px_reg;
        end
    end

    assign ram_we    = clear_busy_reg || s1_valid_reg;
    assign ram_waddr = clear_busy_reg ? clear_addr_reg : s1_addr_reg;
    assign ram_wdata = clear_busy_reg ? '0 : {s1_px_reg, up1};

    assign push               = s1_valid_reg && s1_emit_reg;
    assign push_job.win       = win_next;
    assign push_job.meta.row  = s1_row_reg;
    assign push_job.meta.col  = s1_col_reg;
    assign push_job.meta.last = s1_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_busy_reg <= 1'b1;
            clear_addr_reg <= '0;
            col_reg        <= '0;
            row_reg        <= '0;
            s1_valid_reg   <= 1'b0;
            fwd_hit_reg    <= 1'b0;
            win_reg        <= '0;
        end
        else
        begin
            if (clear_busy_reg)
            begin
                clear_addr_reg <= clear_addr_reg + ADDR_W'(1);
                if (clear_addr_reg == ADDR_W'(MAX_WIDTH - 1))
                begin
                    clear_busy_reg <= 1'b0;
                end
            end
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= acc;
            win_reg      <= win_next;
            fwd_hit_reg  <= acc && s1_valid_reg && (s1_addr_reg == cur_c[ADDR_W-1:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_px_reg   <= pix.pixel;
            s1_addr_reg <= cur_c[ADDR_W-1:0];
            s1_emit_reg <= emit;
            s1_row_reg  <= cur_r - ROW_W'(1);
            s1_col_reg  <= cur_c - COL_W'(1);
            s1_last_reg <= last_px;
            fwd_a_reg   <= s1_px_reg;
            fwd_b_reg   <= up1;
        end
    end

    a_fwd_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_hit_reg |-> s1_valid_reg)
        else $error("forwarding flagged without an item in the store stage");

    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        clear_busy_reg |-> !s1_valid_reg)
        else $error("item in the store stage during the line store clear");

    a_clear_length: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(clear_busy_reg) |-> $past(clear_addr_reg) == ADDR_W'(MAX_WIDTH - 1))
        else $error("line store clear ended early");

    a_interior_only: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (s1_row_reg != '0) && (s1_col_reg != '0))
        else $error("job pushed for a border pixel");
endmodule

>>> design/cpf_back.sv
// Back end: kernel sum, division by the kernel divisor, offset and saturation.
// Depends on cpf_pkg and cpf_result_if; pulls jobs from cpf_queue.

module cpf_back (
    input  logic           clk,
    input  logic           rst_n,
    input  cpf_pkg::cfg_t  cfg,
    input  logic           q_valid,
    input  cpf_pkg::job_t  q_job,
    output logic           q_pop,
    cpf_result_if.source   res
);
    import cpf_pkg::*;

    logic                    st1_valid_reg;
    logic signed [SUM_W-1:0] st1_sum_reg;
    div_e                    st1_div_reg;
    logic                    st1_off_reg;
    meta_t                   st1_meta_reg;

    logic             st2_valid_reg;
    logic             st2_neg_reg;
    logic [MAG_W-1:0] st2_q_reg;
    logic             st2_off_reg;
    meta_t            st2_meta_reg;

    logic  out_valid_reg;
    pix_t  out_pix_reg;
    meta_t out_meta_reg;

    logic                        en;
    logic signed [SUM_W-1:0]     pe [9];
    logic signed [SUM_W-1:0]     sum_next;
    logic [SUM_W-1:0]            abs_v;
    logic [MAG_W-1:0]            mag;
    logic [MAG_W+RECIP_W-1:0]    prod;
    logic [MAG_W-1:0]            q_next;
    logic signed [MAG_W+1:0]     sv;
    logic signed [MAG_W+1:0]     v;
    pix_t                        sat;

    // the whole back end moves together; stall only when the output is held
    assign en    = !out_valid_reg || res.ready;
    assign q_pop = en && q_valid;

    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            pe[i] = $signed({{(SUM_W-PIX_W){1'b0}}, q_job.win[i]});
        end
        case (kind_e'(cfg.kind))
            FK_SMOOTH:
                sum_next = pe[1] + pe[3] + pe[5] + pe[7] + (pe[4] <<< 2);
            FK_EMBOSS:
                sum_next = pe[4] + pe[5] + pe[7] + (pe[8] <<< 1)
                         - (pe[0] <<< 1) - pe[1] - pe[3];
            FK_SHARPEN:
                sum_next = (pe[4] <<< 3) + pe[4] - pe[1] - pe[3] - pe[5] - pe[7];
            FK_LAPLACE:
                sum_next = (pe[4] <<< 3) - pe[0] - pe[1] - pe[2] - pe[3]
                         - pe[5] - pe[6] - pe[7] - pe[8];
            FK_RELIEF_DIAG:
                sum_next = pe[0] - pe[8];
            FK_RELIEF_VERT:
                sum_next = pe[1] - pe[7];
            default:
                sum_next = pe[4];
        endcase
    end

    // divide the magnitude so that the quotient truncates toward zero
    assign abs_v = st1_sum_reg[SUM_W-1] ? SUM_W'(-st1_sum_reg) : SUM_W'(st1_sum_reg);
    assign mag   = abs_v[MAG_W-1:0];
    assign prod  = mag * RECIP_5;

    always_comb
    begin
        case (st1_div_reg)
            DIV_1:   q_next = mag;
            DIV_2:   q_next = mag >> 1;
            DIV_4:   q_next = mag >> 2;
            DIV_5:   q_next = MAG_W'(prod >> RECIP_SH);
            DIV_8:   q_next = mag >> 3;
            default: q_next = mag;
        endcase
    end

    assign sv = st2_neg_reg ? -$signed({2'b00, st2_q_reg}) : $signed({2'b00, st2_q_reg});
    assign v  = sv + (st2_off_reg ? (MAG_W+2)'(OFFSET) : '0);

    always_comb
    begin
        if (v < 0)
        begin
            sat = '0;
        end
        else if (v > (MAG_W+2)'(255))
        begin
            sat = '1;
        end
        else
        begin
            sat = v[PIX_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st1_valid_reg <= 1'b0;
            st2_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            st1_valid_reg <= q_valid;
            st2_valid_reg <= st1_valid_reg;
            out_valid_reg <= st2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st1_sum_reg  <= sum_next;
            st1_div_reg  <= kernel_div(cfg.kind);
            st1_off_reg  <= kernel_offset(cfg.kind);
            st1_meta_reg <= q_job.meta;
            st2_neg_reg  <= st1_sum_reg[SUM_W-1];
            st2_q_reg    <= q_next;
            st2_off_reg  <= st1_off_reg;
            st2_meta_reg <= st1_meta_reg;
            out_pix_reg  <= sat;
            out_meta_reg <= st2_meta_reg;
        end
    end

    assign res.valid      = out_valid_reg;
    assign res.filtered   = out_pix_reg;
    assign res.centre_row = out_meta_reg.row;
    assign res.centre_col = out_meta_reg.col;
    assign res.last       = out_meta_reg.last;
endmodule

>>> design/conv3x3_preset_filter_unit.sv
// Top level of the 3x3 preset convolution filter.
// Depends on cpf_pkg, both channel interfaces, cpf_regs, cpf_front, cpf_queue, cpf_back.
//
//   port   dir   handshake          carries
//   pix    in    valid / ready      pixel[7:0], frame_start
//   res    out   valid / ready      filtered[7:0], centre_row[11:0], centre_col[9:0], last
//   apb    in    psel/penable/...   filter_kind @0x0, line_width @0x4, frame_height @0x8
//
// One pixel per clock sustained while pix.ready is high; the line store takes one read and one write per pixel.
// A pixel's result is registered in the store stage, the job queue, then st1, st2 and the output register.
// After reset all 1024 line store entries are cleared with pix.ready low;
// register writes are taken during that time.
// The four-entry job queue absorbs output stalls; pix.ready drops once the queue count
// plus any item in the store stage reaches four.

module conv3x3_preset_filter_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    cpf_pixel_if.sink                    pix,
    cpf_result_if.source                 res,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [cpf_pkg::PADDR_W-1:0]  paddr,
    input  logic [cpf_pkg::PDATA_W-1:0]  pwdata,
    output logic [cpf_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);
    import cpf_pkg::*;

    cfg_t              cfg;
    logic              push;
    job_t              push_job;
    logic              pop;
    logic              q_valid;
    job_t              q_job;
    logic [QCNT_W-1:0] q_count;

    cpf_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cpf_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .pix      (pix),
        .cfg      (cfg),
        .q_count  (q_count),
        .push     (push),
        .push_job (push_job)
    );

    cpf_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_job    (q_job),
        .count    (q_count)
    );

    cpf_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .q_valid (q_valid),
        .q_job   (q_job),
        .q_pop   (pop),
        .res     (res)
    );
endmodule
